/* src/pfc_pkg.sv */
// Shared types, constants and lookup functions for the Playfair digraph cipher core.
package pfc_pkg;

    localparam int LETTER_W = 5;
    localparam int POS_W = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 25;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;
    localparam logic [LETTER_W-1:0] LETTER_Z = 5'd25;

    localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SQUARE_ROW0 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SQUARE_ROW1 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SQUARE_ROW2 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SQUARE_ROW3 = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SQUARE_ROW4 = 3'd5;

    typedef logic [4:0][LETTER_W-1:0] row_t;
    typedef logic [4:0][4:0][LETTER_W-1:0] square_t;

    localparam square_t SQUARE_RESET = {25'd27025109, 25'd21613104, 25'd16201099,
                                        25'd10755269, 25'd4294688};

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } pos_t;

    typedef struct packed {
        logic [LETTER_W-1:0] a_letter;
        logic [LETTER_W-1:0] b_letter;
        logic                dec;
        logic                b_filler;
        logic                emit_a;
        logic                emit_b;
        logic                last;
    } job_t;

    function automatic logic [LETTER_W-1:0] fold(logic [LETTER_W-1:0] v);
        return (v == LETTER_J) ? LETTER_I : v;
    endfunction

    // The last matching entry in scan order wins; no match gives row 0, column 0.
    function automatic pos_t locate(square_t sq, logic [LETTER_W-1:0] v);
        pos_t p;
        p = '0;
        for (int r = 0; r < 5; r++)
        begin
            for (int c = 0; c < 5; c++)
            begin
                if (sq[r][c] == v)
                begin
                    p.row = POS_W'(r);
                    p.col = POS_W'(c);
                end
            end
        end
        return p;
    endfunction

    function automatic logic [POS_W-1:0] add5(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 4'd5)
        begin
            s = s - 4'd5;
        end
        return s[POS_W-1:0];
    endfunction

endpackage

/* src/playfair_digraph_cipher_core.sv */
// Top level of the Playfair digraph cipher core: configuration registers and stream ports.
//
// Letters enter one word per cycle while the job queue has room and no extra filler job
// is waiting; the front end pairs them, and each pair becomes at most one job. The back end
// turns a job into one or two result words and sends out one word per cycle through its
// output register while the output is not stalled, so the sustained rate is about one input
// word per cycle, slower for each inserted filler. That single output register sets the
// rate. The first result word of a pair passes through the job queue and the output
// register before it is offered, and the second result word follows it out of the back
// end's second-word register. Configuration writes are always taken and must only be made
// while no word is in flight.
module playfair_digraph_cipher_core
#(
    parameter int QUEUE_DEPTH = pfc_pkg::QUEUE_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // letter_in, zero pad
    input  logic                              s_axis_tuser,  // filler_in
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,  // letter_out, zero pad
    output logic                              m_axis_tuser,  // filler_out
    output logic                              m_axis_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pfc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pfc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pfc_pkg::*;

    logic    direction_reg;
    square_t square_reg;

    logic    fq_valid, fq_ready;
    job_t    fq_job;
    logic    qb_valid, qb_ready;
    job_t    qb_job;
    logic [LETTER_W-1:0] out_letter;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            square_reg <= SQUARE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DIRECTION:   direction_reg <= cfg_data[0];
                REG_SQUARE_ROW0: square_reg[0] <= cfg_data;
                REG_SQUARE_ROW1: square_reg[1] <= cfg_data;
                REG_SQUARE_ROW2: square_reg[2] <= cfg_data;
                REG_SQUARE_ROW3: square_reg[3] <= cfg_data;
                REG_SQUARE_ROW4: square_reg[4] <= cfg_data;
                default:         direction_reg <= direction_reg;
            endcase
        end
    end

    pfc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .direction (direction_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_letter (s_axis_tdata[LETTER_W-1:0]),
        .in_filler (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    pfc_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_job   (fq_job),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_job   (qb_job)
    );

    pfc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .square     (square_reg),
        .job_valid  (qb_valid),
        .job_ready  (qb_ready),
        .job        (qb_job),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_letter (out_letter),
        .out_filler (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_letter};

endmodule

/* src/pfc_front.sv */
// Front end: accepts letters, forms digraphs, inserts fillers when encrypting and issues pair jobs.
module pfc_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          direction,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pfc_pkg::LETTER_W-1:0]  in_letter,
    input  logic                          in_filler,
    input  logic                          in_last,
    output logic                          job_valid,
    input  logic                          job_ready,
    output pfc_pkg::job_t                 job
);
    import pfc_pkg::*;

    logic [LETTER_W-1:0] held_letter_reg, held_letter_next;
    logic                held_valid_reg, held_valid_next;
    logic                held_filler_reg, held_filler_next;
    logic                extra_valid_reg, extra_valid_next;
    job_t                extra_reg, extra_next;

    logic accept;
    job_t job0, job1;
    logic job0_v, job1_v;

    assign in_ready = !extra_valid_reg && job_ready;
    assign accept = in_valid && in_ready;

    always_comb
    begin
        held_letter_next = held_letter_reg;
        held_valid_next = held_valid_reg;
        held_filler_next = held_filler_reg;
        job0 = '0;
        job1 = '0;
        job0_v = 1'b0;
        job1_v = 1'b0;
        if (accept)
        begin
            if (direction)
            begin
                if (!held_valid_reg)
                begin
                    if (!in_last)
                    begin
                        held_letter_next = in_letter;
                        held_filler_next = in_filler;
                        held_valid_next = 1'b1;
                    end
                end
                else
                begin
                    job0.a_letter = held_letter_reg;
                    job0.b_letter = in_letter;
                    job0.dec = 1'b1;
                    job0.b_filler = 1'b0;
                    job0.emit_a = !held_filler_reg;
                    job0.emit_b = !in_filler;
                    job0.last = 1'b1;
                    job0_v = !held_filler_reg || !in_filler;
                    held_valid_next = 1'b0;
                    held_filler_next = 1'b0;
                end
            end
            else
            begin
                job0.dec = 1'b0;
                job0.emit_a = 1'b1;
                job0.emit_b = 1'b1;
                job1.dec = 1'b0;
                job1.emit_a = 1'b1;
                job1.emit_b = 1'b1;
                job1.a_letter = in_letter;
                job1.b_letter = LETTER_Z;
                job1.b_filler = 1'b1;
                job1.last = 1'b1;
                held_filler_next = 1'b0;
                if (!held_valid_reg)
                begin
                    if (in_last)
                    begin
                        job0.a_letter = in_letter;
                        job0.b_letter = LETTER_Z;
                        job0.b_filler = 1'b1;
                        job0.last = 1'b1;
                        job0_v = 1'b1;
                    end
                    else
                    begin
                        held_letter_next = in_letter;
                        held_valid_next = 1'b1;
                    end
                end
                else if (fold(held_letter_reg) == fold(in_letter))
                begin
                    job0.a_letter = held_letter_reg;
                    job0.b_letter = LETTER_X;
                    job0.b_filler = 1'b1;
                    job0.last = !in_last;
                    job0_v = 1'b1;
                    if (in_last)
                    begin
                        job1_v = 1'b1;
                        held_valid_next = 1'b0;
                    end
                    else
                    begin
                        held_letter_next = in_letter;
                        held_valid_next = 1'b1;
                    end
                end
                else
                begin
                    job0.a_letter = held_letter_reg;
                    job0.b_letter = in_letter;
                    job0.b_filler = 1'b0;
                    job0.last = 1'b1;
                    job0_v = 1'b1;
                    held_valid_next = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        extra_valid_next = extra_valid_reg;
        extra_next = extra_reg;
        if (accept && job1_v)
        begin
            extra_valid_next = 1'b1;
            extra_next = job1;
        end
        else if (extra_valid_reg && job_ready)
        begin
            extra_valid_next = 1'b0;
        end
    end

    assign job_valid = extra_valid_reg || (accept && job0_v);
    assign job = extra_valid_reg ? extra_reg : job0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_letter_reg <= '0;
            held_valid_reg <= 1'b0;
            held_filler_reg <= 1'b0;
            extra_valid_reg <= 1'b0;
        end
        else
        begin
            held_letter_reg <= held_letter_next;
            held_valid_reg <= held_valid_next;
            held_filler_reg <= held_filler_next;
            extra_valid_reg <= extra_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        extra_reg <= extra_next;
    end

endmodule

/* src/pfc_queue.sv */
// Short job queue between the front end and the cipher back end.
module pfc_queue
#(
    parameter int DEPTH = pfc_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  pfc_pkg::job_t  wr_job,
    output logic           rd_valid,
    input  logic           rd_ready,
    output pfc_pkg::job_t  rd_job
);
    import pfc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_job = mem[rd_ptr_reg];
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

/* src/pfc_back.sv */
// Back end: looks up a pair in the key square, applies the cipher rule and emits letters.
module pfc_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pfc_pkg::square_t              square,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  pfc_pkg::job_t                 job,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pfc_pkg::LETTER_W-1:0]  out_letter,
    output logic                          out_filler,
    output logic                          out_last
);
    import pfc_pkg::*;

    logic                out_valid_reg;
    logic [LETTER_W-1:0] out_letter_reg;
    logic                out_filler_reg;
    logic                out_last_reg;
    logic                sec_valid_reg;
    logic [LETTER_W-1:0] sec_letter_reg;
    logic                sec_filler_reg;
    logic                sec_last_reg;

    logic                slot_free;
    logic                take;
    pos_t                pa, pb;
    logic [POS_W-1:0]    step;
    logic [LETTER_W-1:0] oa, ob;

    assign slot_free = !out_valid_reg || out_ready;
    assign job_ready = !sec_valid_reg && slot_free;
    assign take = job_valid && job_ready;

    always_comb
    begin
        pa = locate(square, fold(job.a_letter));
        pb = locate(square, fold(job.b_letter));
        step = job.dec ? POS_W'(4) : POS_W'(1);
        if (pa.row == pb.row)
        begin
            oa = square[pa.row][add5(pa.col, step)];
            ob = square[pb.row][add5(pb.col, step)];
        end
        else if (pa.col == pb.col)
        begin
            oa = square[add5(pa.row, step)][pa.col];
            ob = square[add5(pb.row, step)][pb.col];
        end
        else
        begin
            oa = square[pa.row][pb.col];
            ob = square[pb.row][pa.col];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
            sec_valid_reg <= job.emit_a && job.emit_b;
        end
        else if (sec_valid_reg && slot_free)
        begin
            out_valid_reg <= 1'b1;
            sec_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sec_letter_reg <= ob;
            sec_filler_reg <= job.b_filler;
            sec_last_reg <= job.last;
            if (job.emit_a)
            begin
                out_letter_reg <= oa;
                out_filler_reg <= 1'b0;
                out_last_reg <= job.last && !job.emit_b;
            end
            else
            begin
                out_letter_reg <= ob;
                out_filler_reg <= job.b_filler;
                out_last_reg <= job.last;
            end
        end
        else if (sec_valid_reg && slot_free)
        begin
            out_letter_reg <= sec_letter_reg;
            out_filler_reg <= sec_filler_reg;
            out_last_reg <= sec_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_letter = out_letter_reg;
    assign out_filler = out_filler_reg;
    assign out_last = out_last_reg;

endmodule

/* src/pfc_checker.sv */
// Port-level checks for the Playfair digraph cipher core, bound to the top level.
module pfc_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [7:0]                        m_axis_tdata,
    input logic                              m_axis_tuser,
    input logic                              m_axis_tlast,
    input logic                              cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("Stalled result word changed.");

    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:5] == 3'b000)
        else $error("Result word has nonzero pad bits.");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("Configuration write was stalled.");

    a_no_early_out: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("Result word appeared straight out of reset.");

endmodule

bind playfair_digraph_cipher_core pfc_checker u_checker (.*);
